// ----- hw/rtl/itoa_pkg.sv -----
// Shared types and constants for the signed integer to decimal text converter.
`timescale 1ns / 1ps

package itoa_pkg;

    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_MINUS   = 8'd45;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [3:0] BCD_ADJ_MIN  = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD  = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT,
        ST_NEWLINE
    } t_state;

    typedef enum logic [1:0] {
        SEL_MINUS,
        SEL_DIGIT,
        SEL_NEWLINE
    } t_char_sel;

    // controller -> datapath
    typedef struct packed {
        logic      load;
        logic      conv_step;
        logic      digit_shift;
        logic      emit;
        t_char_sel sel;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic neg;
        logic top_zero;
        logic out_free;
    } t_status;

endpackage

// ----- hw/rtl/itoa_dp.sv -----
// Datapath: magnitude, shift-add-3 BCD register, character count, output register.
`timescale 1ns / 1ps

module itoa_dp #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  itoa_pkg::t_cmd         i_cmd,
    output itoa_pkg::t_status      o_status,
    input  logic                   i_ready,
    output logic                   o_valid,
    output logic [7:0]             o_text_char,
    output logic                   o_is_last,
    output logic [3:0]             o_text_length
);

    localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;

    logic [VALUE_WIDTH-1:0] r_bin;
    logic [4*NDIG-1:0]      r_bcd;
    logic                   r_neg;
    logic [3:0]             r_count;
    logic                   r_valid;
    logic [7:0]             r_char;
    logic                   r_last;
    logic [3:0]             r_len;
    logic [4*NDIG-1:0]      w_adj;
    logic [3:0]             w_top;
    logic [7:0]             w_char;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        logic [3:0] v_dig;
        v_dig = '0;
        for (int d = 0; d < NDIG; d++) begin
            v_dig = r_bcd[4*d +: 4];
            w_adj[4*d +: 4] = (v_dig >= itoa_pkg::BCD_ADJ_MIN) ?
                              v_dig + itoa_pkg::BCD_ADJ_ADD : v_dig;
        end
    end

    assign w_top = r_bcd[4*NDIG-1 -: 4];

    always_comb begin
        case (i_cmd.sel)
            itoa_pkg::SEL_MINUS:   w_char = itoa_pkg::CHAR_MINUS;
            itoa_pkg::SEL_DIGIT:   w_char = itoa_pkg::CHAR_ZERO + {4'd0, w_top};
            itoa_pkg::SEL_NEWLINE: w_char = itoa_pkg::CHAR_NEWLINE;
            default:               w_char = itoa_pkg::CHAR_NEWLINE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg   <= i_value[VALUE_WIDTH-1];
            r_bin   <= i_value[VALUE_WIDTH-1] ? (~i_value + VALUE_WIDTH'(1)) : i_value;
            r_bcd   <= '0;
            r_count <= '0;
        end else if (i_cmd.conv_step) begin
            r_bin <= {r_bin[VALUE_WIDTH-2:0], 1'b0};
            r_bcd <= {w_adj[4*NDIG-2:0], r_bin[VALUE_WIDTH-1]};
        end else if (i_cmd.digit_shift) begin
            r_bcd <= {r_bcd[4*NDIG-5:0], 4'd0};
        end
        if (i_cmd.emit) begin
            r_count <= r_count + 4'd1;
            r_char  <= w_char;
            r_last  <= (i_cmd.sel == itoa_pkg::SEL_NEWLINE);
            r_len   <= (i_cmd.sel == itoa_pkg::SEL_NEWLINE) ? r_count + 4'd1 : 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_status.neg      = r_neg;
    assign o_status.top_zero = (w_top == 4'd0);
    assign o_status.out_free = !r_valid || i_ready;

    assign o_valid       = r_valid;
    assign o_text_char   = r_char;
    assign o_is_last     = r_last;
    assign o_text_length = r_len;

endmodule

// ----- hw/rtl/itoa_ctrl.sv -----
// Controller: sequences load, binary-to-BCD steps, sign, digit and newline output.
`timescale 1ns / 1ps

module itoa_ctrl #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  itoa_pkg::t_status i_status,
    output itoa_pkg::t_cmd    o_cmd
);

    localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCW  = $clog2(VALUE_WIDTH);
    localparam int DCW  = $clog2(NDIG);

    itoa_pkg::t_state r_state, n_state;
    logic [BCW-1:0]   r_bit_cnt, n_bit_cnt;
    logic [DCW-1:0]   r_dig_cnt, n_dig_cnt;
    logic             r_started, n_started;
    logic             w_bit_last;
    logic             w_dig_last;

    assign w_bit_last = (r_bit_cnt == BCW'(VALUE_WIDTH - 1));
    assign w_dig_last = (r_dig_cnt == DCW'(NDIG - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= itoa_pkg::ST_IDLE;
            r_bit_cnt <= '0;
            r_dig_cnt <= '0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
            r_dig_cnt <= n_dig_cnt;
            r_started <= n_started;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_bit_cnt       = r_bit_cnt;
        n_dig_cnt       = r_dig_cnt;
        n_started       = r_started;
        o_ready         = 1'b0;
        o_cmd.load        = 1'b0;
        o_cmd.conv_step   = 1'b0;
        o_cmd.digit_shift = 1'b0;
        o_cmd.emit        = 1'b0;
        o_cmd.sel         = itoa_pkg::SEL_DIGIT;
        case (r_state)
            itoa_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_bit_cnt  = '0;
                    n_state    = itoa_pkg::ST_CONV;
                end
            end
            itoa_pkg::ST_CONV: begin
                o_cmd.conv_step = 1'b1;
                n_bit_cnt       = r_bit_cnt + BCW'(1);
                if (w_bit_last) begin
                    n_dig_cnt = '0;
                    n_started = 1'b0;
                    n_state   = i_status.neg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_DIGIT;
                end
            end
            itoa_pkg::ST_SIGN: begin
                o_cmd.sel = itoa_pkg::SEL_MINUS;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = itoa_pkg::ST_DIGIT;
                end
            end
            itoa_pkg::ST_DIGIT: begin
                o_cmd.sel = itoa_pkg::SEL_DIGIT;
                if (i_status.top_zero && !r_started && !w_dig_last) begin
                    // leading zero: drop it without output
                    o_cmd.digit_shift = 1'b1;
                    n_dig_cnt         = r_dig_cnt + DCW'(1);
                end else if (i_status.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.digit_shift = 1'b1;
                    n_started         = 1'b1;
                    if (w_dig_last) begin
                        n_state = itoa_pkg::ST_NEWLINE;
                    end else begin
                        n_dig_cnt = r_dig_cnt + DCW'(1);
                    end
                end
            end
            itoa_pkg::ST_NEWLINE: begin
                o_cmd.sel = itoa_pkg::SEL_NEWLINE;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = itoa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = itoa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/signed_int_to_decimal_ascii.sv -----
// Top level: signed integer to decimal ASCII text, one character per item.
//
// Input channel (i_valid / o_ready / i_value): one signed two's complement
// integer per item. o_ready is high only while the converter is idle.
// Output channel (o_valid / i_ready): one character per item, most
// significant first: '-' for a negative value, the digits without leading
// zeros ('0' for zero), then a newline with o_is_last set and o_text_length
// holding the character count including the newline. Other items carry 0.
// Sequence: after an item is taken, the magnitude goes through a shift-add-3
// binary to BCD converter, one bit per cycle. Leading zero digits are then
// dropped one per cycle, and each character leaves as soon as the output
// register is free. NDIG, the BCD digit count, is 10 for 32 bits. A single
// output register holds the current character; a stalled receiver freezes
// the sequence, and the last character may still wait there while the next
// item is accepted. Reset (synchronous, active low) returns to idle and
// empties the output register.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_text_char,
    output logic                   o_is_last,
    output logic [3:0]             o_text_length
);

    itoa_pkg::t_cmd    w_cmd;
    itoa_pkg::t_status w_status;

    // sequencing: load, BCD conversion, leading-zero skip, character output
    itoa_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // magnitude, BCD digits and the output register
    itoa_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (i_value),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_text_char   (o_text_char),
        .o_is_last     (o_is_last),
        .o_text_length (o_text_length)
    );

endmodule

// ----- hw/rtl/itoa_chk.sv -----
// Port-level checker for the converter, bound to the top level.
`timescale 1ns / 1ps

module itoa_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_text_char,
    input logic       o_is_last,
    input logic [3:0] o_text_length
);

    // a stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_text_char) && $stable(o_is_last))
        else $error("output item changed while stalled");

    // the closing item is a newline with a count from two to twelve
    a_last_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_last |-> o_text_char == itoa_pkg::CHAR_NEWLINE &&
                                 o_text_length >= 4'd2 && o_text_length <= 4'd12)
        else $error("bad closing item");

    // other items carry no count and no newline
    a_mid_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_last |-> o_text_length == 4'd0 &&
                                  o_text_char != itoa_pkg::CHAR_NEWLINE)
        else $error("bad inner item");

    // a taken value keeps the input side busy during conversion
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted again during conversion");

endmodule

bind signed_int_to_decimal_ascii itoa_chk u_itoa_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_text_char   (o_text_char),
    .o_is_last     (o_is_last),
    .o_text_length (o_text_length)
);

// ----- sim/tb_signed_int_to_decimal_ascii.sv -----
// Self-checking testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

    // The limit leaves a wide margin for long random stalls on both sides.
    localparam int RUN_LIMIT   = 400000;
    localparam int DRAIN_WAIT  = 80;    // cycles after the last character
    localparam int ITEMS_PHASE = 27;    // random items per flow-control phase

    // Expected character stream for every accepted value, oldest first.
    class ascii_text_scoreboard;
        typedef struct {
            logic [7:0] ch;
            logic       last;
            logic [3:0] len;
        } t_text_char;

        t_text_char expected_chars[$];
        int         n_mismatch = 0;
        int         n_checked  = 0;

        // Render one value as sign, digits and newline.
        function void note_value(logic [31:0] value);
            logic [32:0] magnitude;
            logic [7:0]  digit_chars[$];
            t_text_char  item;
            int          n_chars;
            n_chars = 0;
            // 33 bits so the most negative value keeps its full magnitude
            magnitude = value[31] ? ({1'b0, ~value} + 33'd1) : {1'b0, value};
            do begin
                digit_chars.push_front(itoa_pkg::CHAR_ZERO + 8'(magnitude % 33'd10));
                magnitude = magnitude / 33'd10;
            end while (magnitude != 0);
            item.last = 1'b0;
            item.len  = 4'd0;
            if (value[31]) begin
                item.ch = itoa_pkg::CHAR_MINUS;
                expected_chars.push_back(item);
                n_chars++;
            end
            foreach (digit_chars[k]) begin
                item.ch = digit_chars[k];
                expected_chars.push_back(item);
                n_chars++;
            end
            item.ch   = itoa_pkg::CHAR_NEWLINE;
            item.last = 1'b1;
            item.len  = 4'(n_chars + 1);
            expected_chars.push_back(item);
        endfunction

        function void check_char(logic [7:0] ch, logic last, logic [3:0] len);
            t_text_char want;
            n_checked++;
            if (expected_chars.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("[%0t] unexpected char 0x%02h last=%0b len=%0d",
                             $realtime, ch, last, len);
                return;
            end
            want = expected_chars.pop_front();
            if (ch !== want.ch || last !== want.last || len !== want.len) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("[%0t] char mismatch: exp 0x%02h/%0b/%0d got 0x%02h/%0b/%0d",
                             $realtime, want.ch, want.last, want.len, ch, last, len);
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_text_char;
    logic        o_is_last;
    logic [3:0]  o_text_length;

    ascii_text_scoreboard text_check = new();

    int send_idle_pct  = 0;    // chance per cycle that the sender holds off
    int recv_stall_pct = 0;    // chance per cycle that the receiver stalls
    int n_sent         = 0;
    int cycle_count    = 0;

    signed_int_to_decimal_ascii uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_text_char  (o_text_char),
        .o_is_last    (o_is_last),
        .o_text_length(o_text_length)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Receiver: ready decided at the falling edge, characters checked at the
    // rising edge (outputs read before the block's own updates land).
    always @(negedge i_clk) begin
        i_ready <= i_rst_n && !chance(recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            text_check.check_char(o_text_char, o_is_last, o_text_length);
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d chars outstanding",
                     cycle_count, text_check.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one value; random hold-off first, then keep valid and payload
    // steady until o_ready is seen at a rising edge.
    task automatic send_value(logic [31:0] value);
        while (chance(send_idle_pct)) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_value <= value;
        do
            @(posedge i_clk);
        while (!o_ready);
        text_check.note_value(value);
        n_sent++;
    endtask

    // Sender goes quiet until every expected character has come out.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (text_check.pending() != 0)
            @(posedge i_clk);
    endtask

    // Mix of full-range words, random digit counts, values near the two
    // extremes and small values around zero.
    function automatic logic [31:0] random_value();
        longint unsigned bound;
        longint unsigned mag;
        int              n_digits;
        case ($urandom_range(3))
            0: return $urandom;
            1: begin
                n_digits = $urandom_range(1, 10);
                bound = 1;
                repeat (n_digits) bound = bound * 10;
                mag = {$urandom, $urandom} % bound;
                if (mag > 64'h7FFF_FFFF)
                    mag = 64'(mag[30:0]);
                return $urandom_range(1) ? -32'(mag) : 32'(mag);
            end
            2: return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(20)
                                         : 32'h7FFF_FFFF - $urandom_range(20);
            default: return 32'($urandom_range(40)) - 32'd20;
        endcase
    endfunction

    initial begin
        logic [31:0] directed_values [22];
        directed_values = '{
            32'd0, 32'd1, -32'd1, 32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
            -32'd5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
            32'd1000000000, 32'd999999999, -32'd999999999, -32'd1000000000,
            32'd123456789, -32'd123456789, 32'h5555_5555, 32'hAAAA_AAAA,
            32'hFFFF_FFFE, 32'd2
        };

        // Synchronous reset, then release
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed values at full rate: zero, the extremes, digit-count
        // boundaries and alternating bit patterns.
        foreach (directed_values[k])
            send_value(directed_values[k]);
        wait_drained();

        // Random values across four flow-control phases:
        // free flow, sparse input, stalled output, light idling on both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            repeat (ITEMS_PHASE)
                send_value(random_value());
            wait_drained();
        end

        // Let any trailing activity show up before the verdict.
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Rendered %0d values (directed extremes, zero, random widths and signs)",
                 n_sent);
        $display("into %0d characters under free, sparse, stalled and mixed flow control",
                 text_check.n_checked);
        if (text_check.n_mismatch == 0 && text_check.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
